### rtl/nmea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA framer package
// Phase and status codes, state and result types, and the hex digit decoder
// shared by the framer modules.
// ----------------------------------------------------------------------------
package nmea_pkg;

	localparam int unsigned CHAR_W = 8;
	localparam int unsigned CFG_IDX_W = 1;

	// Reset values of the configuration registers.
	localparam logic [CHAR_W-1:0] START_CHAR_RESET = 8'd36;
	localparam logic [CHAR_W-1:0] CHECK_CHAR_RESET = 8'd42;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_CHAR = 1'd1;

	// Frame phase codes.
	localparam logic [2:0] PH_SEARCH = 3'd0;
	localparam logic [2:0] PH_DATA   = 3'd1;
	localparam logic [2:0] PH_HIGH   = 3'd2;
	localparam logic [2:0] PH_LOW    = 3'd3;
	localparam logic [2:0] PH_TERM1  = 3'd4;
	localparam logic [2:0] PH_TERM2  = 3'd5;
	localparam logic [2:0] PH_VALID  = 3'd6;
	localparam logic [2:0] PH_ERROR  = 3'd7;

	// Frame status codes.
	localparam logic [1:0] ST_BUSY = 2'd0;
	localparam logic [1:0] ST_OK   = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	typedef struct packed {
		logic [2:0]        phase;
		logic [CHAR_W-1:0] payload_xor;
		logic [3:0]        high_digit;
		logic              high_digit_ok;
	} frame_state_t;

	typedef struct packed {
		logic [1:0]        frame_status;
		logic              sentence_valid;
		logic [CHAR_W-1:0] running_checksum;
	} frame_result_t;

	// Decodes an ASCII hex digit; bit 4 is set when the character is a hex digit.
	function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'd48 && c <= 8'd57) begin
			r = {1'b1, 4'(c - 8'd48)};
		end else if (c >= 8'd65 && c <= 8'd70) begin
			r = {1'b1, 4'(c - 8'd55)};
		end else if (c >= 8'd97 && c <= 8'd102) begin
			r = {1'b1, 4'(c - 8'd87)};
		end
		return r;
	endfunction

endpackage

### rtl/nmea_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA framer channels
// Valid/ready channels for received characters and for framer results.
// ----------------------------------------------------------------------------
interface nmea_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nmea_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] frame_status;
	logic       sentence_valid;
	logic [7:0] running_checksum;

	modport source (output valid, output frame_status, output sentence_valid,
		output running_checksum, input ready);
	modport sink   (input valid, input frame_status, input sentence_valid,
		input running_checksum, output ready);
endinterface

### rtl/nmea_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA framer step logic
// Computes the next frame state and the result for one received character.
// ----------------------------------------------------------------------------
module nmea_step
	import nmea_pkg::*;
(
	input  frame_state_t        cur,
	input  logic [CHAR_W-1:0]   rx_byte,
	input  logic [CHAR_W-1:0]   start_char,
	input  logic [CHAR_W-1:0]   check_char,
	output frame_state_t        nxt,
	output frame_result_t       res
);

	logic [4:0] hex;
	logic       match;

	assign hex = hex_decode(rx_byte);
	assign match = hex[4] && cur.high_digit_ok &&
		(cur.high_digit == cur.payload_xor[7:4]) && (hex[3:0] == cur.payload_xor[3:0]);

	always_comb begin
		nxt = cur;
		res.frame_status = ST_BUSY;
		unique case (cur.phase)
			PH_DATA: begin
				if (rx_byte == check_char) begin
					nxt.phase = PH_HIGH;
				end else begin
					nxt.payload_xor = cur.payload_xor ^ rx_byte;
				end
			end
			PH_HIGH: begin
				nxt.high_digit_ok = hex[4];
				nxt.high_digit    = hex[3:0];
				nxt.phase         = PH_LOW;
			end
			PH_LOW: begin
				if (match) begin
					nxt.phase = PH_TERM1;
				end else begin
					nxt.phase        = PH_ERROR;
					res.frame_status = ST_ERR;
				end
			end
			PH_TERM1: begin
				nxt.phase = PH_TERM2;
			end
			PH_TERM2: begin
				nxt.phase        = PH_VALID;
				res.frame_status = ST_OK;
			end
			default: begin
				// Search, and the byte after a valid or failed sentence.
				if (rx_byte == start_char) begin
					nxt.phase       = PH_DATA;
					nxt.payload_xor = '0;
				end else begin
					nxt.phase = PH_SEARCH;
				end
			end
		endcase
		res.sentence_valid   = (nxt.phase == PH_VALID);
		res.running_checksum = nxt.payload_xor;
	end

endmodule

### rtl/nmea_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA framer output register
// Holds one result item for the receiver and tells the input side when a new
// result can be loaded.
// ----------------------------------------------------------------------------
module nmea_out_stage
	import nmea_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  frame_result_t     res,
	output logic              can_load,
	nmea_out_if.source        out_ch
);

	logic          valid_q;
	frame_result_t res_q;

	// A new result may enter when the register is empty or drains this cycle.
	assign can_load = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_q <= res;
		end
	end

	assign out_ch.valid            = valid_q;
	assign out_ch.frame_status     = res_q.frame_status;
	assign out_ch.sentence_valid   = res_q.sentence_valid;
	assign out_ch.running_checksum = res_q.running_checksum;

endmodule

### rtl/nmea_sentence_checksum_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA sentence checksum framer
// Frames NMEA 0183 style sentences from a character stream and checks the
// two hex digit checksum against the XOR of the payload.
// ----------------------------------------------------------------------------
// Each input item on in_ch is one received character. For every accepted
// item the block returns exactly one result item on out_ch: the frame status
// (busy, sentence OK, or checksum error), a flag that is high while the
// framer sits in the valid-sentence state, and the running payload XOR.
// The start and checksum marker characters are set through the write port
// (index 0 and index 1); the user must do so only while the block is idle,
// which the block itself does not enforce. A result appears on out_ch the
// cycle after its item is accepted. The block takes one item per cycle
// while the receiver takes results, a rate set by the single output register
// that follows the step logic. When the receiver stalls, the output register
// holds its result and in_ch stays ready only if that result is taken in the
// same cycle; no item is lost or repeated. Reset empties the output register,
// restores the marker characters to '$' and '*', and puts the framer in start
// search with a cleared checksum.
// ----------------------------------------------------------------------------
module nmea_sentence_checksum_framer
	import nmea_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CHAR_W-1:0]    cfg_wdata,
	nmea_in_if.sink              in_ch,
	nmea_out_if.source           out_ch
);

	logic [CHAR_W-1:0] start_char_q;
	logic [CHAR_W-1:0] check_char_q;
	frame_state_t      state_q;
	frame_state_t      state_nxt;
	frame_result_t     step_res;
	logic              can_load;
	logic              accept;

	// Registers: the user must write only while the framer is idle; unenforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_char_q <= START_CHAR_RESET;
			check_char_q <= CHECK_CHAR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_CHAR: start_char_q <= cfg_wdata;
				CFG_CHECK_CHAR: check_char_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// An item is taken whenever the output register can accept its result.
	assign in_ch.ready = can_load;
	assign accept      = in_ch.valid && can_load;

	// Frame state advances once per accepted character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_SEARCH, payload_xor: '0, high_digit: '0,
				high_digit_ok: 1'b0};
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	nmea_step u_step (
		.cur        (state_q),
		.rx_byte    (in_ch.rx_byte),
		.start_char (start_char_q),
		.check_char (check_char_q),
		.nxt        (state_nxt),
		.res        (step_res)
	);

	nmea_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (in_ch.valid),
		.res      (step_res),
		.can_load (can_load),
		.out_ch   (out_ch)
	);

endmodule

### bench/tb_nmea_sentence_checksum_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA sentence checksum framer testbench
// Feeds character streams built from well-formed, damaged and cut-off
// sentences plus line noise. Every result is checked against a cycle-free
// model of the framer. Both channels stall at random. One long receiver
// hold-off fills the block. The marker characters go through several
// settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_checksum_framer;
	import nmea_pkg::*;

	// Number of random characters and the split into configuration phases.
	localparam int unsigned RANDOM_CHARS = 1550;
	localparam int unsigned CFG_PHASES   = 4;
	// Cycles the receiver holds off once, while the sender keeps offering.
	localparam int unsigned HOLD_CYCLES  = 400;
	// Cycles with no item moving on either channel before the run is abandoned.
	localparam int unsigned STALL_LIMIT  = 3000;
	// Quiet cycles before a register write and at the end, so that anything
	// still in flight has left the block.
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned IDLE_PERCENT  = 37;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	// Kinds of damage applied to a generated sentence.
	typedef enum logic [1:0] {
		FLAW_NONE,
		FLAW_DIGIT,
		FLAW_TRUNC
	} flaw_t;

	// ------------------------------------------------------------------------
	// Framer model and store of expected results. Each accepted character is
	// stepped through the model at once; since every character yields exactly
	// one result, the store holds one entry per character still in the block.
	// ------------------------------------------------------------------------
	class framer_scoreboard;
		logic [7:0]    start_char;
		logic [7:0]    check_char;
		logic [2:0]    phase;
		logic [7:0]    xor_acc;
		logic [3:0]    hi_nibble;
		logic          hi_valid;
		frame_result_t expected_q[$];
		int unsigned   errors;

		function new();
			start_char = START_CHAR_RESET;
			check_char = CHECK_CHAR_RESET;
			phase      = PH_SEARCH;
			xor_acc    = 8'h00;
			hi_nibble  = 4'h0;
			hi_valid   = 1'b0;
			errors     = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
			if (idx == CFG_START_CHAR) begin
				start_char = value;
			end else begin
				check_char = value;
			end
		endfunction

		// Decodes one ASCII hex digit of either case; anything else is not a digit
		// and decodes to zero.
		function bit decode_digit(input logic [7:0] c, output logic [3:0] nibble);
			nibble = 4'h0;
			if (c >= "0" && c <= "9") begin
				nibble = 4'(c - "0");
				return 1'b1;
			end
			if (c >= "A" && c <= "F") begin
				nibble = 4'(c - "A" + 10);
				return 1'b1;
			end
			if (c >= "a" && c <= "f") begin
				nibble = 4'(c - "a" + 10);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_char(logic [7:0] c);
			frame_result_t r;
			logic [3:0]    lo_nibble;
			bit            lo_valid;
			r.frame_status = ST_BUSY;
			case (phase)
				PH_DATA: begin
					// The marker wins over the start character when the two are equal.
					if (c == check_char) begin
						phase = PH_HIGH;
					end else begin
						xor_acc = xor_acc ^ c;
					end
				end
				PH_HIGH: begin
					hi_valid = decode_digit(c, hi_nibble);
					phase    = PH_LOW;
				end
				PH_LOW: begin
					lo_valid = decode_digit(c, lo_nibble);
					if (lo_valid && hi_valid && hi_nibble == xor_acc[7:4] &&
							lo_nibble == xor_acc[3:0]) begin
						phase = PH_TERM1;
					end else begin
						phase          = PH_ERROR;
						r.frame_status = ST_ERR;
					end
				end
				PH_TERM1: begin
					phase = PH_TERM2;
				end
				PH_TERM2: begin
					phase          = PH_VALID;
					r.frame_status = ST_OK;
				end
				default: begin
					// Search, and the byte right after a valid or failed sentence.
					if (c == start_char) begin
						phase   = PH_DATA;
						xor_acc = 8'h00;
					end else begin
						phase = PH_SEARCH;
					end
				end
			endcase
			r.sentence_valid   = (phase == PH_VALID);
			r.running_checksum = xor_acc;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [1:0] status, logic valid, logic [7:0] checksum);
			frame_result_t e;
			if (expected_q.size() == 0) begin
				$error("result with no character pending: status %0d valid %0d checksum %0h",
					status, valid, checksum);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (status !== e.frame_status) begin
				$error("frame_status mismatch: expected %0d, actual %0d", e.frame_status, status);
				errors++;
			end
			if (valid !== e.sentence_valid) begin
				$error("sentence_valid mismatch: expected %0d, actual %0d",
					e.sentence_valid, valid);
				errors++;
			end
			if (checksum !== e.running_checksum) begin
				$error("running_checksum mismatch: expected %02h, actual %02h",
					e.running_checksum, checksum);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CHAR_W-1:0]    cfg_wdata;

	nmea_in_if  in_ch ();
	nmea_out_if out_ch ();

	nmea_sentence_checksum_framer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	framer_scoreboard sb;

	// Marker characters as currently programmed, used to build sentences.
	logic [7:0] start_r;
	logic [7:0] check_r;
	// Payload of the next sentence to send.
	logic [7:0] payload_q[$];

	bit          tx_idle_en;
	bit          rx_idle_en;
	bit          hold_req;
	bit          hold_done;
	int unsigned items_sent;
	int unsigned stall_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Results are checked at the rising edge, on the values that stood before
	// the edge. A result leaves the output register only after its character
	// has been accepted, so the expectation is already stored when it is taken.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			sb.check_result(out_ch.frame_status, out_ch.sentence_valid,
				out_ch.running_checksum);
		end
	end

	// Watchdog: a run in which nothing moves for too long has hung.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stall_count <= 0;
		end else begin
			stall_count <= stall_count + 1;
			if (stall_count >= STALL_LIMIT) begin
				$display("tb_nmea_sentence_checksum_framer: FAIL");
				$finish;
			end
		end
	end

	// Receiver. Ready changes only at the falling edge. Once, on request, it
	// holds off for a long stretch, so the block fills up and must stall the
	// sender; otherwise it drops ready at random while idling is enabled.
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ch.ready <= !(rx_idle_en && $urandom_range(99) < IDLE_PERCENT);
		end
	end

	// Offers one character and returns at the falling edge after it is
	// accepted, with valid still high so that back-to-back items stay
	// back-to-back. Each idle cycle drives valid low exactly once.
	task automatic send_char(input logic [7:0] c);
		while (tx_idle_en && $urandom_range(99) < IDLE_PERCENT) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.rx_byte <= c;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_char(c);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nibble, input bit lower);
		if (nibble < 4'd10) begin
			return 8'("0") + 8'(nibble);
		end
		return (lower ? 8'("a") : 8'("A")) + 8'(nibble) - 8'd10;
	endfunction

	// Sends start, payload_q, marker, two checksum digits and two terminators.
	// A digit flaw spoils one digit, by a random byte or by a wrong value; a
	// cut-off sentence stops after the payload, so the framer keeps gathering
	// payload from whatever follows.
	task automatic send_sentence(input flaw_t flaw, input bit lower);
		logic [7:0] sum;
		logic [7:0] hi_c;
		logic [7:0] lo_c;
		sum = 8'h00;
		send_char(start_r);
		foreach (payload_q[i]) begin
			sum ^= payload_q[i];
			send_char(payload_q[i]);
		end
		if (flaw != FLAW_TRUNC) begin
			send_char(check_r);
			hi_c = hex_char(sum[7:4], lower);
			lo_c = hex_char(sum[3:0], lower);
			if (flaw == FLAW_DIGIT) begin
				case ($urandom_range(2))
					0: hi_c = 8'($urandom_range(255));
					1: lo_c = 8'($urandom_range(255));
					default: lo_c = hex_char(sum[3:0] ^ 4'($urandom_range(1, 15)), lower);
				endcase
			end
			send_char(hi_c);
			send_char(lo_c);
			// Terminator values are not checked, so now and then send junk there.
			if ($urandom_range(3) == 0) begin
				send_char(8'($urandom_range(255)));
				send_char(8'($urandom_range(255)));
			end else begin
				send_char(CHAR_CR);
				send_char(CHAR_LF);
			end
		end
	endtask

	// Registers are written only with the block drained: the sender stops,
	// every expected result must have arrived, and a few cycles pass.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_register(idx, value);
		if (idx == CFG_START_CHAR) begin
			start_r = value;
		end else begin
			check_r = value;
		end
	endtask

	// One random chunk of stream: mostly good sentences with random payload,
	// then damaged checksums, cut-off sentences and plain noise.
	task automatic send_random_chunk();
		int unsigned kind;
		int unsigned len;
		logic [7:0]  c;
		kind = $urandom_range(99);
		if (kind >= 90) begin
			repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(255)));
		end else begin
			// Short payloads dominate; a few long ones exercise longer XOR chains.
			len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
			payload_q.delete();
			repeat (len) begin
				do c = 8'($urandom_range(255)); while (c == check_r);
				payload_q.push_back(c);
			end
			if (kind < 70) begin
				send_sentence(FLAW_NONE, 1'($urandom_range(1)));
			end else if (kind < 82) begin
				send_sentence(FLAW_DIGIT, 1'($urandom_range(1)));
			end else begin
				send_sentence(FLAW_TRUNC, 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		int unsigned phase_start;
		logic [7:0]  start_v;
		logic [7:0]  check_v;

		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_START_CHAR;
		cfg_wdata     = 8'h00;
		in_ch.valid   = 1'b0;
		in_ch.rx_byte = 8'h00;
		sb            = new();
		start_r       = START_CHAR_RESET;
		check_r       = CHECK_CHAR_RESET;
		tx_idle_en    = 1'b1;
		rx_idle_en    = 1'b1;
		hold_req      = 1'b0;
		hold_done     = 1'b0;
		items_sent    = 0;
		stall_count   = 0;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, on the reset markers. A zero byte while searching is
		// ignored. Payload bytes 0xFF and 0x00 give checksum FF, sent in lower
		// case.
		send_char(8'h00);
		payload_q = '{8'hFF, 8'h00};
		send_sentence(FLAW_NONE, 1'b1);
		// A start character inside the payload is XORed like any other byte.
		payload_q = '{START_CHAR_RESET};
		send_sentence(FLAW_NONE, 1'b0);
		// Empty payload with a non-hex first digit: checksum error on the
		// second digit.
		send_char(START_CHAR_RESET);
		send_char(CHECK_CHAR_RESET);
		send_char("G");
		send_char("0");

		// Start and marker equal: the byte opens a sentence while searching and
		// closes the payload once inside one. The framer is still in the error
		// state, so the start also checks that an error goes back to search.
		write_register(CFG_START_CHAR, 8'h7E);
		write_register(CFG_CHECK_CHAR, 8'h7E);
		payload_q = '{8'h78};
		send_sentence(FLAW_NONE, 1'b0);

		// Random part in several marker settings: the usual markers, both
		// extremes each way round, and a random pair. The second setting runs
		// with no idling at all; the first carries the long receiver hold-off.
		for (int unsigned ph = 0; ph < CFG_PHASES; ph++) begin
			case (ph)
				0: begin
					start_v = START_CHAR_RESET;
					check_v = CHECK_CHAR_RESET;
				end
				1: begin
					start_v = 8'h00;
					check_v = 8'hFF;
				end
				2: begin
					start_v = 8'hFF;
					check_v = 8'h00;
				end
				default: begin
					start_v = 8'($urandom_range(255));
					check_v = 8'($urandom_range(255));
				end
			endcase
			write_register(CFG_START_CHAR, start_v);
			write_register(CFG_CHECK_CHAR, check_v);
			tx_idle_en  = (ph != 1);
			rx_idle_en  = (ph != 1);
			phase_start = items_sent;
			while (items_sent < phase_start + RANDOM_CHARS / CFG_PHASES) begin
				if (ph == 0 && !hold_req && items_sent >= phase_start + 150) begin
					hold_req = 1'b1;
				end
				send_random_chunk();
			end
		end

		// Drain: everything sent must come back, then a short quiet stretch
		// catches any stray result.
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb_nmea_sentence_checksum_framer: PASS");
		end else begin
			$display("tb_nmea_sentence_checksum_framer: FAIL");
		end
		$finish;
	end

endmodule

### nmea_sentence_checksum_framer.f
rtl/nmea_pkg.sv
rtl/nmea_if.sv
rtl/nmea_step.sv
rtl/nmea_out_stage.sv
rtl/nmea_sentence_checksum_framer.sv
bench/tb_nmea_sentence_checksum_framer.sv
